>>> sv/gwcg_pkg.sv
// ----------------------------------------------------------------------------
// gwcg_pkg
// Shared types and codes for the guarded weight class gate.
// ----------------------------------------------------------------------------
package gwcg_pkg;

	// Operating modes
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_STATIC  = 2'd1;
	localparam logic [1:0] MODE_DYNAMIC = 2'd2;

	// Formal states
	localparam logic [1:0] ST_DISABLED = 2'd0;
	localparam logic [1:0] ST_OK       = 2'd2;

	// Classifier codes
	localparam logic [2:0] CLS_HIGH    = 3'd2;
	localparam logic [2:0] CLS_PENDING = 3'd3;

	// Item kinds
	localparam logic CMD_SAMPLE   = 1'b0;
	localparam logic CMD_SET_MODE = 1'b1;

	// Reason codes
	localparam logic [3:0] RS_OFF      = 4'd0;
	localparam logic [3:0] RS_SWITCH   = 4'd1;
	localparam logic [3:0] RS_DISABLED = 4'd2;
	localparam logic [3:0] RS_FAULT    = 4'd3;
	localparam logic [3:0] RS_CAL      = 4'd4;
	localparam logic [3:0] RS_STALE    = 4'd5;
	localparam logic [3:0] RS_PENDING  = 4'd6;
	localparam logic [3:0] RS_INVALID  = 4'd7;
	localparam logic [3:0] RS_ACTIVE   = 4'd8;

	// Sample flag bits
	localparam int FLAG_ENABLED = 0;
	localparam int FLAG_FAULT   = 1;
	localparam int FLAG_CAL     = 2;

	// Register map
	localparam int          ADDR_BITS          = 3;
	localparam logic        REG_STALE_TIMEOUT  = 1'b0;
	localparam logic [31:0] STALE_TIMEOUT_RST  = 32'd250;

	// One input transaction
	typedef struct packed {
		logic               cmd;
		logic        [2:0]  sample_flags;
		logic        [31:0] sample_seq;
		logic        [31:0] sample_time_ms;
		logic        [31:0] now_time_ms;
		logic        [2:0]  static_class_code;
		logic        [2:0]  dynamic_class_code;
		logic signed [31:0] weight_ug;
		logic        [1:0]  new_mode;
		logic        [31:0] expected_gen;
		logic               check_gen;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic        [1:0]  weigh_state;
		logic               is_qualified;
		logic               ok_entered;
		logic               state_moved;
		logic signed [31:0] weight_out_ug;
		logic        [3:0]  reason_code;
		logic               accepted;
		logic        [31:0] generation_out;
	} result_t;

endpackage

>>> sv/gwcg_in_stage.sv
// ----------------------------------------------------------------------------
// gwcg_in_stage
// Input register: holds one accepted transaction until the gate consumes it.
// ----------------------------------------------------------------------------
module gwcg_in_stage import gwcg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	// free when empty or when the held item leaves this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> sv/gwcg_decide.sv
// ----------------------------------------------------------------------------
// gwcg_decide
// Gate state and the single-pass guard chain for mode sets and samples.
// ----------------------------------------------------------------------------
module gwcg_decide import gwcg_pkg::*; #(
	parameter int SEQ_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [31:0] stale_timeout_ms,
	output result_t     result
);

	logic [1:0]          mode_q;
	logic [31:0]         gen_q;
	logic                armed_q;
	logic [SEQ_BITS-1:0] switch_seq_q;
	logic [SEQ_BITS-1:0] last_seq_q;
	logic [1:0]          state_q;
	logic [3:0]          reason_q;

	logic [1:0]          mode_d;
	logic [31:0]         gen_d;
	logic                armed_d;
	logic [SEQ_BITS-1:0] switch_seq_d;
	logic [SEQ_BITS-1:0] last_seq_d;
	logic [1:0]          state_d;
	logic [3:0]          reason_d;

	logic [SEQ_BITS-1:0] seq;
	logic [31:0]         age;
	logic [2:0]          cand;
	logic                qual;
	logic                ok_in;
	logic                acc;

	assign seq  = item.sample_seq[SEQ_BITS-1:0];
	assign age  = item.now_time_ms - item.sample_time_ms;
	assign cand = (mode_q == MODE_STATIC) ? item.static_class_code : item.dynamic_class_code;

	// guard chain
	always_comb begin
		mode_d       = mode_q;
		gen_d        = gen_q;
		armed_d      = armed_q;
		switch_seq_d = switch_seq_q;
		last_seq_d   = last_seq_q;
		state_d      = state_q;
		reason_d     = reason_q;
		qual         = 1'b0;
		ok_in        = 1'b0;
		acc          = 1'b1;
		case (item.cmd)
			CMD_SET_MODE: begin
				if (item.new_mode > MODE_DYNAMIC ||
				    (item.check_gen && item.expected_gen != gen_q)) begin
					acc = 1'b0;
				end else if (item.new_mode != mode_q) begin
					mode_d       = item.new_mode;
					gen_d        = gen_q + 32'd1;
					armed_d      = 1'b0;
					switch_seq_d = last_seq_q;
					state_d      = ST_DISABLED;
					reason_d     = (item.new_mode == MODE_OFF) ? RS_OFF : RS_SWITCH;
				end
			end
			CMD_SAMPLE: begin
				last_seq_d = seq;
				state_d    = ST_DISABLED;
				if (mode_q == MODE_OFF) begin
					reason_d = RS_OFF;
				end else if (!item.sample_flags[FLAG_ENABLED]) begin
					reason_d = RS_DISABLED;
				end else if (item.sample_flags[FLAG_FAULT]) begin
					reason_d = RS_FAULT;
				end else if (item.sample_flags[FLAG_CAL]) begin
					reason_d = RS_CAL;
				end else if (age > stale_timeout_ms) begin
					reason_d = RS_STALE;
				end else if (!armed_q) begin
					// first fresh sequence after a switch arms the gate
					if (seq != switch_seq_q) begin
						armed_d      = 1'b1;
						switch_seq_d = seq;
					end
					reason_d = RS_SWITCH;
				end else if (seq == switch_seq_q) begin
					reason_d = RS_SWITCH;
				end else if (cand == CLS_PENDING) begin
					reason_d = RS_PENDING;
				end else if (cand > CLS_HIGH) begin
					reason_d = RS_INVALID;
				end else begin
					reason_d = RS_ACTIVE;
					state_d  = cand[1:0] + 2'd1;
					qual     = 1'b1;
					ok_in    = (state_d == ST_OK) && (state_q != ST_OK);
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	// result fields
	always_comb begin
		result.weigh_state    = state_d;
		result.is_qualified   = qual;
		result.ok_entered     = ok_in;
		result.state_moved    = (state_d != state_q);
		result.weight_out_ug  = (item.cmd == CMD_SAMPLE) ? item.weight_ug : 32'sd0;
		result.reason_code    = reason_d;
		result.accepted       = acc;
		result.generation_out = gen_d;
	end

	// gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			gen_q        <= '0;
			armed_q      <= 1'b0;
			switch_seq_q <= '0;
			last_seq_q   <= '0;
			state_q      <= ST_DISABLED;
			reason_q     <= RS_OFF;
		end else if (fire) begin
			mode_q       <= mode_d;
			gen_q        <= gen_d;
			armed_q      <= armed_d;
			switch_seq_q <= switch_seq_d;
			last_seq_q   <= last_seq_d;
			state_q      <= state_d;
			reason_q     <= reason_d;
		end
	end

endmodule

>>> sv/gwcg_out_stage.sv
// ----------------------------------------------------------------------------
// gwcg_out_stage
// Result register: holds a finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
module gwcg_out_stage import gwcg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	assign free = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

>>> sv/guarded_weight_class_gate_core.sv
// ----------------------------------------------------------------------------
// guarded_weight_class_gate_core
// Checkweigher class gate: mode sets with generation check, and a guard
// chain that decides whether a sample's class becomes the formal state.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------
//  input    | in_valid / in_ready    | cmd, sample fields, mode set fields
//  output   | out_valid / out_ready  | weigh_state .. generation_out
//  config   | APB psel/penable       | stale_timeout_ms at byte address 0
//
//  One transaction per cycle while the output does not stall; out_valid
//  rises when the result register loads (guard chain from the input
//  register into the result register).
//  Reset clears the gate state and sets stale_timeout_ms to 250.
//  A stalled output holds its result; the input register takes one more
//  transaction, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module guarded_weight_class_gate_core import gwcg_pkg::*; #(
	parameter int SEQ_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [2:0]           sample_flags,
	input  logic [31:0]          sample_seq,
	input  logic [31:0]          sample_time_ms,
	input  logic [31:0]          now_time_ms,
	input  logic [2:0]           static_class_code,
	input  logic [2:0]           dynamic_class_code,
	input  logic signed [31:0]   weight_ug,
	input  logic [1:0]           new_mode,
	input  logic [31:0]          expected_gen,
	input  logic                 check_gen,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           weigh_state,
	output logic                 is_qualified,
	output logic                 ok_entered,
	output logic                 state_moved,
	output logic signed [31:0]   weight_out_ug,
	output logic [3:0]           reason_code,
	output logic                 accepted,
	output logic [31:0]          generation_out
);

	logic        stale_wr;
	logic [31:0] stale_timeout_q;
	item_t       in_item;
	item_t       item_s1;
	logic        valid_s1;
	logic        fire;
	logic        out_free;
	result_t     res_d;
	result_t     res_s2;

	// configuration register
	assign pready   = 1'b1;
	assign stale_wr = psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_STALE_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_timeout_q <= STALE_TIMEOUT_RST;
		end else if (stale_wr) begin
			stale_timeout_q <= pwdata;
		end
	end

	assign prdata = (paddr[ADDR_BITS-1] == REG_STALE_TIMEOUT) ? stale_timeout_q : 32'd0;

	// pack input fields
	always_comb begin
		in_item.cmd                = cmd;
		in_item.sample_flags       = sample_flags;
		in_item.sample_seq         = sample_seq;
		in_item.sample_time_ms     = sample_time_ms;
		in_item.now_time_ms        = now_time_ms;
		in_item.static_class_code  = static_class_code;
		in_item.dynamic_class_code = dynamic_class_code;
		in_item.weight_ug          = weight_ug;
		in_item.new_mode           = new_mode;
		in_item.expected_gen       = expected_gen;
		in_item.check_gen          = check_gen;
	end

	assign fire = valid_s1 && out_free;

	gwcg_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gwcg_decide #(
		.SEQ_BITS (SEQ_BITS)
	) u_decide (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.item             (item_s1),
		.stale_timeout_ms (stale_timeout_q),
		.result           (res_d)
	);

	gwcg_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (res_d),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_s2)
	);

	// unpack result fields
	assign weigh_state    = res_s2.weigh_state;
	assign is_qualified   = res_s2.is_qualified;
	assign ok_entered     = res_s2.ok_entered;
	assign state_moved    = res_s2.state_moved;
	assign weight_out_ug  = res_s2.weight_out_ug;
	assign reason_code    = res_s2.reason_code;
	assign accepted       = res_s2.accepted;
	assign generation_out = res_s2.generation_out;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for guarded_weight_class_gate_core. A directed pass walks the
// mode set rules and every sample guard in priority order. The stale
// timeout register is then swept through its extremes. Random traffic
// follows, with gaps on the input and stalls on the output. Every result
// is checked field by field against a cycle-free model of the gate. That
// model is updated on each accepted input transaction.
// ----------------------------------------------------------------------------
module tb_top import gwcg_pkg::*; ();

	localparam int SEQ_W = 32;
	localparam logic [31:0] SEQ_MASK = {32{1'b1}} >> (32 - SEQ_W);
	localparam int STALL_LIMIT = 1000;

	// codes the package leaves unnamed
	localparam logic [1:0] MODE_BAD = 2'd3;
	localparam logic [2:0] CLS_LOW = 3'd0;
	localparam logic [2:0] CLS_OK = 3'd1;
	localparam logic [2:0] CLS_INVALID_LO = 3'd4;
	localparam logic [2:0] CLS_INVALID_HI = 3'd7;
	localparam logic [2:0] FL_ON = 3'(1 << FLAG_ENABLED);
	localparam logic [2:0] FL_FAULT = 3'(1 << FLAG_FAULT);
	localparam logic [2:0] FL_CAL = 3'(1 << FLAG_CAL);
	localparam logic [ADDR_BITS-1:0] TIMEOUT_ADDR = {REG_STALE_TIMEOUT, 2'b00};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic cmd;
	logic [2:0] sample_flags;
	logic [31:0] sample_seq, sample_time_ms, now_time_ms;
	logic [2:0] static_class_code, dynamic_class_code;
	logic signed [31:0] weight_ug;
	logic [1:0] new_mode;
	logic [31:0] expected_gen;
	logic check_gen;
	logic out_valid, out_ready;
	logic [1:0] weigh_state;
	logic is_qualified, ok_entered, state_moved;
	logic signed [31:0] weight_out_ug;
	logic [3:0] reason_code;
	logic accepted;
	logic [31:0] generation_out;

	guarded_weight_class_gate_core #(.SEQ_BITS(SEQ_W)) u_top (.*);

	// gate model state
	logic [1:0] gate_mode = MODE_OFF;
	logic [31:0] gate_gen = '0;
	logic gate_armed = 1'b0;
	logic [31:0] gate_switch_seq = '0;
	logic [31:0] gate_last_seq = '0;
	logic [1:0] gate_state = ST_DISABLED;
	logic [3:0] gate_reason = RS_OFF;
	logic [31:0] stale_limit = STALE_TIMEOUT_RST;

	result_t verdict_q[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit in_gaps = 1'b1;
	bit out_stalls = 1'b1;
	logic [31:0] run_seq = 32'h100;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gate decision for one transaction; advances the model state.
	function automatic result_t gate_verdict(input item_t it);
		result_t r;
		logic [1:0] prior;
		logic [31:0] seq, age;
		logic [2:0] cls;
		logic [3:0] why;
		r = '0;
		r.accepted = 1'b1;
		prior = gate_state;
		if (it.cmd == CMD_SET_MODE) begin
			if (it.new_mode > MODE_DYNAMIC || (it.check_gen && it.expected_gen != gate_gen)) begin
				r.accepted = 1'b0;
			end else if (it.new_mode != gate_mode) begin
				gate_mode = it.new_mode;
				gate_gen = gate_gen + 32'd1;
				gate_armed = 1'b0;
				gate_switch_seq = gate_last_seq;
				gate_state = ST_DISABLED;
				gate_reason = (it.new_mode == MODE_OFF) ? RS_OFF : RS_SWITCH;
			end
		end else begin
			seq = it.sample_seq & SEQ_MASK;
			age = it.now_time_ms - it.sample_time_ms;
			cls = (gate_mode == MODE_STATIC) ? it.static_class_code : it.dynamic_class_code;
			r.weight_out_ug = it.weight_ug;
			gate_last_seq = seq;
			// guards in priority order
			if (gate_mode == MODE_OFF)
				why = RS_OFF;
			else if (!it.sample_flags[FLAG_ENABLED])
				why = RS_DISABLED;
			else if (it.sample_flags[FLAG_FAULT])
				why = RS_FAULT;
			else if (it.sample_flags[FLAG_CAL])
				why = RS_CAL;
			else if (age > stale_limit)
				why = RS_STALE;
			else if (!gate_armed) begin
				// a fresh sequence arms the gate but still reports the switch
				if (seq != gate_switch_seq) begin
					gate_armed = 1'b1;
					gate_switch_seq = seq;
				end
				why = RS_SWITCH;
			end else if (seq == gate_switch_seq)
				why = RS_SWITCH;
			else if (cls == CLS_PENDING)
				why = RS_PENDING;
			else if (cls > CLS_HIGH)
				why = RS_INVALID;
			else
				why = RS_ACTIVE;
			gate_reason = why;
			if (why == RS_ACTIVE) begin
				gate_state = cls[1:0] + 2'd1;
				r.is_qualified = 1'b1;
				r.ok_entered = (gate_state == ST_OK) && (prior != ST_OK);
			end else begin
				gate_state = ST_DISABLED;
			end
		end
		r.weigh_state = gate_state;
		r.state_moved = (gate_state != prior);
		r.reason_code = gate_reason;
		r.generation_out = gate_gen;
		return r;
	endfunction

	function automatic logic [31:0] fresh_seq();
		run_seq = run_seq + 32'd1;
		return run_seq;
	endfunction

	// random fill for every field of a transaction
	function automatic item_t noise_item();
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	// sample transaction; mode fields carry noise
	function automatic item_t sample_item(input logic [2:0] flags, input logic [31:0] seq,
			input logic [31:0] now, input logic [31:0] age, input logic [2:0] cs,
			input logic [2:0] cd, input logic [31:0] w);
		item_t it;
		it = noise_item();
		it.cmd = CMD_SAMPLE;
		it.sample_flags = flags;
		it.sample_seq = seq;
		it.now_time_ms = now;
		it.sample_time_ms = now - age;
		it.static_class_code = cs;
		it.dynamic_class_code = cd;
		it.weight_ug = w;
		return it;
	endfunction

	// mode set transaction; sample fields carry noise
	function automatic item_t mode_item(input logic [1:0] mode, input logic chk,
			input logic [31:0] gen);
		item_t it;
		it = noise_item();
		it.cmd = CMD_SET_MODE;
		it.new_mode = mode;
		it.check_gen = chk;
		it.expected_gen = gen;
		return it;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input item_t it);
		if (in_gaps && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		{cmd, sample_flags, sample_seq, sample_time_ms, now_time_ms, static_class_code,
			dynamic_class_code, weight_ug, new_mode, expected_gen, check_gen} = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off until every pending result has come back
	task automatic drain_gate();
		in_valid = 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
	endtask

	// write the stale timeout while idle, then read it back
	task automatic write_timeout(input logic [31:0] value);
		drain_gate();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = TIMEOUT_ADDR;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		stale_limit = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		check_field("prdata", value, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// mode set rules, each guard in turn, arming and class mapping
	task automatic test_directed();
		send_item(sample_item(FL_ON | FL_FAULT | FL_CAL, 32'h10, '1, '0, CLS_OK, CLS_OK,
			32'h7FFF_FFFF));
		send_item(mode_item(MODE_BAD, 1'b0, '0));
		send_item(mode_item(MODE_STATIC, 1'b1, 32'd5));
		send_item(mode_item(MODE_STATIC, 1'b1, 32'd0));
		send_item(mode_item(MODE_STATIC, 1'b0, '1));
		send_item(sample_item('0, 32'h11, $urandom, '0, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON | FL_FAULT, 32'h12, $urandom, '0, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON | FL_CAL, 32'h13, $urandom, '0, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'h14, $urandom, STALE_TIMEOUT_RST + 32'd1, CLS_OK,
			CLS_OK, $urandom));
		// age at the limit; sequence still at the switch point
		send_item(sample_item(FL_ON, 32'h10, $urandom, STALE_TIMEOUT_RST, CLS_OK, CLS_OK,
			$urandom));
		// wrapped timestamps, new sequence arms
		send_item(sample_item(FL_ON, '1, 32'h10, 32'h20, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, '1, $urandom, '0, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd1, $urandom, '0, CLS_PENDING, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd2, $urandom, '0, CLS_INVALID_LO, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd3, $urandom, '0, CLS_INVALID_HI, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd4, $urandom, '0, CLS_OK, CLS_LOW, $urandom));
		send_item(sample_item(FL_ON, 32'd5, $urandom, '0, CLS_OK, CLS_LOW, $urandom));
		send_item(sample_item(FL_ON, 32'd6, $urandom, '0, CLS_LOW, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd7, $urandom, '0, CLS_HIGH, CLS_OK, 32'h8000_0000));
		send_item(mode_item(MODE_DYNAMIC, 1'b1, 32'd1));
		send_item(sample_item(FL_ON, 32'd8, $urandom, '0, CLS_LOW, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, 32'd9, $urandom, '0, CLS_LOW, CLS_OK, '0));
		send_item(sample_item(FL_ON, 32'd10, $urandom, '0, CLS_OK, CLS_PENDING, $urandom));
		send_item(mode_item(MODE_OFF, 1'b0, '0));
		send_item(sample_item(FL_ON, 32'd11, $urandom, '0, CLS_OK, CLS_OK, $urandom));
	endtask

	// stale timeout at zero, at full scale and at a mid value
	task automatic test_timeout_register();
		write_timeout('0);
		send_item(mode_item(MODE_STATIC, 1'b1, gate_gen));
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, '0, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, '0, CLS_HIGH, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, 32'd1, CLS_OK, CLS_OK, $urandom));
		write_timeout('1);
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, '1, CLS_OK, CLS_OK, $urandom));
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, $urandom, CLS_LOW, CLS_OK,
			$urandom));
		write_timeout(32'd1000);
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, 32'd1000, CLS_OK, CLS_OK,
			$urandom));
		send_item(sample_item(FL_ON, fresh_seq(), $urandom, 32'd1001, CLS_OK, CLS_OK,
			$urandom));
		write_timeout(STALE_TIMEOUT_RST);
	endtask

	// mostly well-formed sample streams, some mode sets, some noise
	task automatic test_random_traffic(input int count);
		item_t it;
		int pick;
		logic [31:0] age, span, seq;
		logic [2:0] flags, cs, cd;
		logic [1:0] mode;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				case (pick)
					0: mode = MODE_OFF;
					1: mode = MODE_BAD;
					2, 3: mode = MODE_STATIC;
					default: mode = MODE_DYNAMIC;
				endcase
				it = mode_item(mode, 1'($urandom),
					($urandom_range(0, 3) == 0) ? $urandom : gate_gen);
			end else if (pick < 14) begin
				it = noise_item();
			end else begin
				span = (stale_limit > 32'd2000) ? 32'd2000 : stale_limit;
				age = $urandom_range(0, span);
				if ($urandom_range(0, 19) == 0)
					age = (stale_limit == '1) ? $urandom : stale_limit + 32'd1;
				seq = ($urandom_range(0, 19) == 0) ? run_seq : fresh_seq();
				flags = ($urandom_range(0, 9) == 0) ? 3'($urandom) : FL_ON;
				cs = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(3, 7)) :
					3'($urandom_range(0, 2));
				cd = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(3, 7)) :
					3'($urandom_range(0, 2));
				it = sample_item(flags, seq, $urandom, age, cs, cd, $urandom);
			end
			send_item(it);
		end
	endtask

	// sender waits for the gate to empty between short bursts
	task automatic test_sender_pause();
		repeat (3) begin
			test_random_traffic(15);
			drain_gate();
		end
	endtask

	// output side stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_stalls && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// predict on input transactions, check on output transactions
	always @(posedge clk) begin : port_watch
		result_t got, want;
		if (arst_n) begin
			if (in_valid && in_ready)
				verdict_q.push_back(gate_verdict({cmd, sample_flags, sample_seq, sample_time_ms,
					now_time_ms, static_class_code, dynamic_class_code, weight_ug, new_mode,
					expected_gen, check_gen}));
			if (out_valid && out_ready) begin
				got = {weigh_state, is_qualified, ok_entered, state_moved, weight_out_ug,
					reason_code, accepted, generation_out};
				if (verdict_q.size() == 0) begin
					$error("result transaction with no pending input");
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					check_field("weigh_state", 32'(want.weigh_state), 32'(got.weigh_state));
					check_field("is_qualified", 32'(want.is_qualified),
						32'(got.is_qualified));
					check_field("ok_entered", 32'(want.ok_entered), 32'(got.ok_entered));
					check_field("state_moved", 32'(want.state_moved), 32'(got.state_moved));
					check_field("weight_out_ug", want.weight_out_ug, got.weight_out_ug);
					check_field("reason_code", 32'(want.reason_code), 32'(got.reason_code));
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("generation_out", want.generation_out, got.generation_out);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** guarded_weight_class_gate_core: FAILED **");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		{cmd, sample_flags, sample_seq, sample_time_ms, now_time_ms, static_class_code,
			dynamic_class_code, weight_ug, new_mode, expected_gen, check_gen} = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_timeout_register();
		test_random_traffic(300);
		test_sender_pause();
		write_timeout($urandom_range(100, 3000));
		test_random_traffic(300);
		// closing stretch at full rate
		in_gaps = 1'b0;
		out_stalls = 1'b0;
		test_random_traffic(60);
		drain_gate();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("** guarded_weight_class_gate_core: PASSED **");
		else
			$display("** guarded_weight_class_gate_core: FAILED **");
		$finish;
	end

endmodule

>>> guarded_weight_class_gate_core.f
sv/gwcg_pkg.sv
sv/gwcg_in_stage.sv
sv/gwcg_decide.sv
sv/gwcg_out_stage.sv
sv/guarded_weight_class_gate_core.sv
dv/tb_top.sv
